FILE: src/mulid_pkg.sv
// Package for the monotonic ULID generator: field widths, character count
// and the Crockford base32 alphabet. No dependencies.
package mulid_pkg;

	localparam int TIME_W   = 48;
	localparam int RAND_HI_W = 16;
	localparam int RAND_LO_W = 64;
	localparam int RAND_W   = RAND_HI_W + RAND_LO_W;
	localparam int CHAR_W   = 8;
	localparam int DIGIT_W  = 5;
	localparam int CHAR_COUNT = 26;
	localparam int CNT_W    = $clog2(CHAR_COUNT);
	// identifier padded on top so the first digit is a full 5-bit group
	localparam int SHIFT_W  = CHAR_COUNT * DIGIT_W;

	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CHAR_COUNT - 1);

	localparam logic [CHAR_W-1:0] ALPHABET [32] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
		8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4D, 8'h4E, 8'h50, 8'h51,
		8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A
	};

endpackage

FILE: src/mulid_if.sv
// Channel interfaces of the monotonic ULID generator: configuration write,
// request and character stream. Depends on mulid_pkg.
interface mulid_cfg_if;
	import mulid_pkg::*;
	logic valid;
	logic ready;
	logic monotonic_mode;
	modport source(output valid, output monotonic_mode, input ready);
	modport sink(input valid, input monotonic_mode, output ready);
endinterface

interface mulid_in_if;
	import mulid_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [TIME_W-1:0]    time_millis;
	logic [RAND_HI_W-1:0] random_high;
	logic [RAND_LO_W-1:0] random_low;
	modport source(output valid, output time_millis, output random_high,
		output random_low, input ready);
	modport sink(input valid, input time_millis, input random_high,
		input random_low, output ready);
endinterface

interface mulid_out_if;
	import mulid_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CHAR_W-1:0]    character;
	logic                 last;
	logic                 overflow;
	logic [TIME_W-1:0]    id_time;
	logic [RAND_HI_W-1:0] id_random_high;
	logic [RAND_LO_W-1:0] id_random_low;
	modport source(output valid, output character, output last, output overflow,
		output id_time, output id_random_high, output id_random_low, input ready);
	modport sink(input valid, input character, input last, input overflow,
		input id_time, input id_random_high, input id_random_low, output ready);
endinterface

FILE: src/monotonic_ulid_generator.sv
// Monotonic ULID generator: one request in, 26 Crockford base32 characters out.
// The first character is valid the cycle after the request transfer.
// Throughput: one character per cycle while rsp.ready is high, or a lone
// overflow marker instead of the text; the next request is taken in the
// cycle of the last character transfer.
// Reset: stored time and random part clear to zero, monotonic mode sets to 1.
module monotonic_ulid_generator (
	input  logic           clk,
	input  logic           arst_n,
	mulid_cfg_if.sink      cfg,
	mulid_in_if.sink       req,
	mulid_out_if.source    rsp
);
	import mulid_pkg::*;

	logic                  mono_q;
	logic [TIME_W-1:0]     last_time_q;
	logic [RAND_W-1:0]     last_rand_q;

	logic                  busy_q;
	logic                  ovf_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SHIFT_W-1:0]    sh_q;
	logic [TIME_W-1:0]     id_time_q;
	logic [RAND_W-1:0]     id_rand_q;

	logic                  req_xfer;
	logic                  rsp_xfer;
	logic                  rsp_last;
	logic [RAND_W-1:0]     fresh;
	logic [RAND_W-1:0]     inc;
	logic                  hit;
	logic [RAND_W-1:0]     used;
	logic                  wrap;

	assign fresh = {req.random_high, req.random_low};
	assign inc   = last_rand_q + RAND_W'(1);
	assign hit   = mono_q && (last_rand_q != '0) && (req.time_millis <= last_time_q);
	assign used  = hit ? inc : fresh;
	assign wrap  = hit && (inc == '0);

	assign rsp_last = ovf_q || (cnt_q == LAST_CNT);
	assign rsp_xfer = rsp.valid && rsp.ready;
	assign req.ready = !busy_q || (rsp.ready && rsp_last);
	assign req_xfer = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q      <= 1'b1;
			last_time_q <= '0;
			last_rand_q <= '0;
			busy_q      <= 1'b0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg.valid) begin
				mono_q <= cfg.monotonic_mode;
			end
			if (req_xfer) begin
				busy_q <= 1'b1;
				ovf_q  <= wrap;
				cnt_q  <= '0;
				if (hit) begin
					last_rand_q <= inc;
				end else if (mono_q) begin
					last_time_q <= req.time_millis;
					last_rand_q <= fresh;
				end
			end else if (rsp_xfer) begin
				if (rsp_last) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// payload: identifier shifts up one digit per non-final character transfer
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			sh_q      <= {(SHIFT_W - TIME_W - RAND_W)'(0), req.time_millis, used};
			id_time_q <= req.time_millis;
			id_rand_q <= used;
		end else if (rsp_xfer && !rsp_last) begin
			sh_q <= sh_q << DIGIT_W;
		end
	end

	assign rsp.valid          = busy_q;
	assign rsp.last           = rsp_last;
	assign rsp.overflow       = ovf_q;
	assign rsp.character      = ovf_q ? '0 : ALPHABET[sh_q[SHIFT_W-1 -: DIGIT_W]];
	assign rsp.id_time        = id_time_q;
	assign rsp.id_random_high = id_rand_q[RAND_W-1 -: RAND_HI_W];
	assign rsp.id_random_low  = id_rand_q[RAND_LO_W-1:0];

endmodule

FILE: src/mulid_checker.sv
// Port-level checks for the monotonic ULID generator and the bind that
// attaches them to the top level. Depends on mulid_pkg.
module mulid_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [mulid_pkg::CHAR_W-1:0]   character,
	input logic                           last,
	input logic                           overflow
);
	import mulid_pkg::*;

	// an overflow result is a lone marker with no text
	a_ovf_marker: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow |-> last && (character == '0))
		else $error("overflow result not a lone empty marker");

	a_text_char: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !overflow |-> character != '0)
		else $error("text result carries no character");

	// more characters follow a non-final transfer
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !last |=> rsp_valid && !overflow)
		else $error("character stream broke off before last");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(character) && $stable(last))
		else $error("stalled result changed");

endmodule

bind monotonic_ulid_generator mulid_checker u_mulid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.character (rsp.character),
	.last      (rsp.last),
	.overflow  (rsp.overflow)
);

FILE: tb/tb_monotonic_ulid_generator.sv
// Testbench for monotonic_ulid_generator: drives requests and register writes,
// predicts the 26-character text (or the overflow marker) and checks each transfer.
// Depends on mulid_pkg and the channel interfaces in mulid_if.sv.
module tb_monotonic_ulid_generator;
	import mulid_pkg::*;

	localparam string DIGITS = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 30;

	typedef struct packed {
		logic [CHAR_W-1:0]    character;
		logic                 last;
		logic                 overflow;
		logic [TIME_W-1:0]    id_time;
		logic [RAND_HI_W-1:0] id_random_high;
		logic [RAND_LO_W-1:0] id_random_low;
	} ulid_char_t;

	class ulid_char_tracker;
		bit                mode;
		logic [TIME_W-1:0] held_time;
		logic [RAND_W-1:0] held_rand;
		ulid_char_t        pending_chars[$];
		int                mismatches;

		function new();
			mode = 1'b1;
			held_time = '0;
			held_rand = '0;
			mismatches = 0;
		endfunction

		// Work out the characters one accepted request must produce.
		function void note_request(logic [TIME_W-1:0] t, logic [RAND_HI_W-1:0] rh,
			logic [RAND_LO_W-1:0] rl);
			logic [RAND_W-1:0] r;
			logic [SHIFT_W-1:0] id;
			ulid_char_t c;
			int pos;
			r = {rh, rl};
			if (mode) begin
				if (held_rand != '0 && t <= held_time) begin
					held_rand = held_rand + 1'b1;
					r = held_rand;
					if (r == '0) begin
						// wrapped past 80 bits: lone marker, no text
						c.character = '0;
						c.last = 1'b1;
						c.overflow = 1'b1;
						c.id_time = t;
						c.id_random_high = '0;
						c.id_random_low = '0;
						pending_chars.push_back(c);
						return;
					end
				end else begin
					held_time = t;
					held_rand = r;
				end
			end
			id = {2'b00, t, r};
			for (int k = 0; k < CHAR_COUNT; k++) begin
				pos = 125 - 5 * k;
				c.character = DIGITS[int'(id[pos +: DIGIT_W])];
				c.last = (k == CHAR_COUNT - 1);
				c.overflow = 1'b0;
				c.id_time = t;
				c.id_random_high = r[RAND_W-1:RAND_LO_W];
				c.id_random_low = r[RAND_LO_W-1:0];
				pending_chars.push_back(c);
			end
		endfunction

		function void check_char(ulid_char_t got);
			ulid_char_t exp;
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected character transfer: char %h last %b ovf %b",
						got.character, got.last, got.overflow);
				return;
			end
			exp = pending_chars.pop_front();
			if (got.character !== exp.character || got.last !== exp.last ||
				got.overflow !== exp.overflow || got.id_time !== exp.id_time ||
				got.id_random_high !== exp.id_random_high ||
				got.id_random_low !== exp.id_random_low) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch exp: char %h last %b ovf %b time %h rnd %h_%h",
						exp.character, exp.last, exp.overflow, exp.id_time,
						exp.id_random_high, exp.id_random_low);
					$display("         got: char %h last %b ovf %b time %h rnd %h_%h",
						got.character, got.last, got.overflow, got.id_time,
						got.id_random_high, got.id_random_low);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count = 0;
	bit   idle_free;
	logic [TIME_W-1:0] last_sent_time;
	ulid_char_tracker ulid_chars = new();

	mulid_cfg_if cfg_ch();
	mulid_in_if  req_ch();
	mulid_out_if rsp_ch();

	monotonic_ulid_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("monotonic_ulid_generator test failed");
			$finish;
		end
	end

	// Request side; valid stays high when the next item follows without a gap.
	task automatic send_request(logic [TIME_W-1:0] t, logic [RAND_HI_W-1:0] rh,
		logic [RAND_LO_W-1:0] rl);
		int gap;
		gap = idle_free ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.time_millis <= t;
		req_ch.random_high <= rh;
		req_ch.random_low <= rl;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		ulid_chars.note_request(t, rh, rl);
		last_sent_time = t;
	endtask

	task automatic wait_drained();
		while (ulid_chars.pending_chars.size() != 0) @(posedge clk);
	endtask

	// Register write, only once every expected character has come out.
	task automatic set_mode(bit m);
		req_ch.valid <= 1'b0;
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.monotonic_mode <= m;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		ulid_chars.mode = m;
	endtask

	task automatic random_requests(int count);
		logic [TIME_W-1:0] t;
		logic [RAND_HI_W-1:0] rh;
		logic [RAND_LO_W-1:0] rl;
		int tk;
		int rk;
		for (int i = 0; i < count; i++) begin
			// mostly same or nearby milliseconds so the increment path is busy
			tk = $urandom_range(0, 9);
			case (tk)
				0, 1, 2, 3: t = last_sent_time;
				4: t = (last_sent_time > 3) ? last_sent_time - $urandom_range(1, 3) : '0;
				5: t = last_sent_time + 1'b1;
				6: t = {16'($urandom), $urandom};
				7: t = '1;
				8: t = '0;
				default: t = last_sent_time + $urandom_range(0, 40);
			endcase
			rk = $urandom_range(0, 9);
			case (rk)
				0: {rh, rl} = '0;
				1: {rh, rl} = '1;
				2: begin
					rh = '1;
					rl = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
				end
				default: begin
					rh = 16'($urandom);
					rl = {$urandom, $urandom};
				end
			endcase
			send_request(t, rh, rl);
		end
	endtask

	// Result side: a fresh stall draw for every character.
	initial begin
		ulid_char_t got;
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_free ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			got.character = rsp_ch.character;
			got.last = rsp_ch.last;
			got.overflow = rsp_ch.overflow;
			got.id_time = rsp_ch.id_time;
			got.id_random_high = rsp_ch.id_random_high;
			got.id_random_low = rsp_ch.id_random_low;
			ulid_chars.check_char(got);
		end
	end

	initial begin
		bit phase_modes [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		idle_free = 1'b0;
		last_sent_time = '0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.monotonic_mode = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.time_millis = '0;
		req_ch.random_high = '0;
		req_ch.random_low = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// monotonic mode from reset
		send_request('0, '0, '0);                       // zero randomness is stored
		send_request(48'd5, '1, '1);                    // taken fresh since stored is zero
		send_request(48'd5, 16'h0001, 64'd7);           // all ones + 1 wraps: overflow
		send_request(48'd3, 16'h1234, '1);              // stored zero again: fresh
		send_request(48'd2, '0, '0);                    // earlier time, carry into upper
		send_request(48'd3, 16'hBEEF, 64'd1);           // same time, increment
		send_request('1, 16'hAAAA, 64'h5555_5555_5555_5555);
		send_request('1, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request('1, '0, '1);
		send_request(48'h5555_5555_5555, 16'h00FF, 64'hFF00_FF00_FF00_FF00);
		// plain mode: nothing stored
		set_mode(1'b0);
		send_request('0, '1, '1);
		send_request('0, '0, '0);
		send_request('1, 16'h0001, 64'h1);
		send_request('1, 16'h0001, 64'h1);
		set_mode(1'b1);
		send_request('0, 16'h7777, 64'h1234_5678_9ABC_DEF0);  // continues stored value

		for (int phase = 0; phase < 6; phase++) begin
			set_mode(phase_modes[phase]);
			idle_free = (phase == 3);
			random_requests(35);
		end
		req_ch.valid <= 1'b0;
		idle_free = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ulid_chars.mismatches == 0 && ulid_chars.pending_chars.size() == 0) begin
			$display("monotonic_ulid_generator test passed");
		end else begin
			$display("monotonic_ulid_generator test failed");
		end
		$finish;
	end

endmodule
